// ===== rtl/core/tpba_pkg.sv =====
// Shared types, constants and layout decoders for the tile pixel bitplane access block.
// Used by tpba_ctrl, tpba_datapath and tile_pixel_bitplane_access; depends on nothing.
package tpba_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int FMT_W  = 5;
  localparam int BASE_W = 16;
  localparam int XY_W   = 4;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 17;

  // Row start and byte address widths: base + 15*16 + 97 stays below 2^18
  localparam int ROW_W  = 17;
  localparam int ADDR_W = 18;
  localparam int OFS_W  = 7;
  localparam int CNT_W  = 4;

  // Slave tdata layout, lowest bit first
  localparam int IN_CMD_LSB  = 0;
  localparam int IN_FMT_LSB  = IN_CMD_LSB + CMD_W;
  localparam int IN_BASE_LSB = IN_FMT_LSB + FMT_W;
  localparam int IN_X_LSB    = IN_BASE_LSB + BASE_W;
  localparam int IN_Y_LSB    = IN_X_LSB + XY_W;
  localparam int IN_WV_LSB   = IN_Y_LSB + XY_W;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_BYTE = 2'd0,
    CMD_READ_BYTE  = 2'd1,
    CMD_GET_PIXEL  = 2'd2,
    CMD_SET_PIXEL  = 2'd3
  } cmd_t;

  // Tile layout codes
  localparam logic [FMT_W-1:0] FMT_BPP2       = 5'd0;
  localparam logic [FMT_W-1:0] FMT_BPP4       = 5'd1;
  localparam logic [FMT_W-1:0] FMT_BPP8       = 5'd2;
  localparam logic [FMT_W-1:0] FMT_DIRECT     = 5'd3;
  localparam logic [FMT_W-1:0] FMT_M7         = 5'd4;
  localparam logic [FMT_W-1:0] FMT_M7_DIRECT  = 5'd5;
  localparam logic [FMT_W-1:0] FMT_M7_EXT     = 5'd6;
  localparam logic [FMT_W-1:0] FMT_LINE2      = 5'd7;
  localparam logic [FMT_W-1:0] FMT_SPR4       = 5'd8;
  localparam logic [FMT_W-1:0] FMT_SPR01      = 5'd9;
  localparam logic [FMT_W-1:0] FMT_SPR23      = 5'd10;
  localparam logic [FMT_W-1:0] FMT_BG_CG0     = 5'd11;
  localparam logic [FMT_W-1:0] FMT_BG_CG1     = 5'd12;
  localparam logic [FMT_W-1:0] FMT_ROW4       = 5'd13;
  localparam logic [FMT_W-1:0] FMT_BPP1       = 5'd14;
  localparam logic [FMT_W-1:0] FMT_PACK4      = 5'd15;
  localparam logic [FMT_W-1:0] FMT_PACK8      = 5'd16;
  localparam logic [FMT_W-1:0] FMT_PACK4_SWAP = 5'd17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  // One memory access of a pixel: byte offset from row start, bit in the byte,
  // bit in the colour, or the whole byte
  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [2:0]       pix;
    logic [2:0]       cbit;
    logic             whole;
  } acc_t;

  typedef struct packed {
    logic       load;
    logic       read;
    logic       modify;
    logic       finish;
    logic [2:0] step;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             out_free;
  } ctl_sts_t;

  function automatic logic is_wide(logic [FMT_W-1:0] fmt);
    return (fmt == FMT_SPR4) || (fmt == FMT_SPR01) || (fmt == FMT_SPR23);
  endfunction

  // log2 of the row stride
  function automatic logic [2:0] stride_shift(logic [FMT_W-1:0] fmt);
    logic [2:0] s;
    s = 3'd1;
    unique case (fmt) inside
      FMT_M7, FMT_M7_DIRECT, FMT_M7_EXT:     s = 3'd4;
      FMT_LINE2, FMT_BPP1:                   s = 3'd0;
      FMT_ROW4, FMT_PACK4, FMT_PACK4_SWAP:   s = 3'd2;
      FMT_PACK8:                             s = 3'd3;
      default:                               s = 3'd1;
    endcase
    return s;
  endfunction

  // Number of memory accesses a pixel takes; zero for unknown layouts
  function automatic logic [CNT_W-1:0] acc_count(logic [FMT_W-1:0] fmt);
    logic [CNT_W-1:0] n;
    n = '0;
    unique case (fmt) inside
      FMT_BPP2, FMT_BG_CG0, FMT_LINE2, FMT_BG_CG1, FMT_SPR01, FMT_SPR23: n = 4'd2;
      FMT_BPP4, FMT_SPR4, FMT_ROW4, FMT_PACK4, FMT_PACK4_SWAP:           n = 4'd4;
      FMT_BPP8, FMT_DIRECT, FMT_PACK8:                                   n = 4'd8;
      FMT_M7, FMT_M7_DIRECT, FMT_M7_EXT, FMT_BPP1:                       n = 4'd1;
      default:                                                           n = '0;
    endcase
    return n;
  endfunction

  // Access k of a pixel at column x
  function automatic acc_t acc_desc(logic [FMT_W-1:0] fmt, logic [XY_W-1:0] x,
                                    logic [2:0] k);
    acc_t d;
    d.offset = '0;
    d.pix    = 3'd7 - x[2:0];
    d.cbit   = k;
    d.whole  = 1'b0;
    unique case (fmt) inside
      FMT_BPP2, FMT_BG_CG0:           d.offset = {6'd0, k[0]};
      FMT_LINE2:                      d.offset = k[0] ? 7'd8 : 7'd0;
      FMT_BPP4, FMT_BPP8, FMT_DIRECT: d.offset = {1'b0, k[2:1], 3'b000, k[0]};
      FMT_BG_CG1: begin
        d.offset = {3'b001, 3'b000, k[0]};
        d.cbit   = {2'b01, k[0]};
      end
      FMT_M7, FMT_M7_DIRECT, FMT_M7_EXT: begin
        d.offset = {2'b00, x, 1'b1};
        d.whole  = 1'b1;
      end
      // Left half of a wide sprite sits one byte after the right half
      FMT_SPR4, FMT_SPR01:            d.offset = {k[1:0], 4'b0000, ~x[3]};
      FMT_SPR23: begin
        d.offset = {1'b1, k[0], 4'b0000, ~x[3]};
        d.cbit   = {2'b01, k[0]};
      end
      FMT_ROW4:                       d.offset = {5'd0, k[1:0]};
      FMT_BPP1:                       d.offset = '0;
      FMT_PACK4: begin
        d.offset = {4'd0, x[3:1]};
        d.pix    = {x[0], k[1:0]};
      end
      FMT_PACK4_SWAP: begin
        d.offset = {4'd0, x[3:1]};
        d.pix    = {~x[0], k[1:0]};
      end
      FMT_PACK8: begin
        d.offset = {3'd0, x};
        d.pix    = k;
      end
      default: d.offset = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/tile_pixel_bitplane_access.sv =====
// Tile pixel bitplane access, top level: byte and pixel access to a tile memory.
// Each item takes N memory accesses (N = 1 for byte commands, Mode 7 and 1-bit layouts,
// up to 8 for 8-bit planar layouts; 0 for a bad pixel column or an unknown layout).
// One item at a time: a transfer is accepted only while the sequencer is idle, and each
// access is a read step then a gather or write-back step. Reset (rst, sync, active high)
// idles the sequencer, empties the output register, sets active size min(MEM_BYTES, 65536).
module tile_pixel_bitplane_access #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: active_size, taken when cfg_wr_en is high
  input  logic                        cfg_wr_en,
  input  logic [tpba_pkg::CFG_W-1:0]  cfg_wr_data,
  // Command stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [1:0] command, [6:2] tile_format, [22:7] tile_address, [26:23] pixel_x,
  // [30:27] pixel_y, [38:31] write_value, [39] zero
  input  logic [tpba_pkg::IN_W-1:0]   s_tdata,
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] read_value, [8] out_of_range, [15:9] zero
  output logic [tpba_pkg::OUT_W-1:0]  m_tdata
);

  tpba_pkg::ctl_cmd_t cmd;
  tpba_pkg::ctl_sts_t sts;

  // Sequencer: accept a transfer when idle, then run read and modify steps for
  // each access and hand the result to the output register once it is free.
  tpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the item, forms each byte address from row start plus layout
  // offset, drops accesses at or past the active size and flags them, gathers or
  // merges colour bits, and holds the result until the sink takes the transfer.
  tpba_datapath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== rtl/core/tpba_ctrl.sv =====
// Sequencer for the tile pixel bitplane access block: steps through the memory
// accesses of one item. Depends on tpba_pkg.
module tpba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tpba_pkg::ctl_sts_t  sts,
  output tpba_pkg::ctl_cmd_t  cmd
);

  tpba_pkg::state_t              state, state_next;
  logic [tpba_pkg::CNT_W-1:0]    step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpba_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step[2:0];
    unique case (state)
      tpba_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = tpba_pkg::ST_READ;
        end
      end
      tpba_pkg::ST_READ: begin
        if (step == sts.count) begin
          state_next = tpba_pkg::ST_DONE;
        end else begin
          cmd.read   = 1'b1;
          state_next = tpba_pkg::ST_MODIFY;
        end
      end
      tpba_pkg::ST_MODIFY: begin
        cmd.modify = 1'b1;
        step_next  = step + 1'b1;
        state_next = tpba_pkg::ST_READ;
      end
      tpba_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = tpba_pkg::ST_IDLE;
        end
      end
      default: state_next = tpba_pkg::ST_IDLE;
    endcase
  end

  assign s_tready = (state == tpba_pkg::ST_IDLE);

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tpba_pkg::ST_MODIFY) |-> (step < sts.count))
    else $error("access step beyond access count");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while output register still held");

  a_load_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == tpba_pkg::ST_READ && step == '0))
    else $error("item accepted without starting its access sequence");

endmodule

// ===== rtl/core/tpba_datapath.sv =====
// Datapath of the tile pixel bitplane access block: item registers, address
// generation, tile memory, bit gather/merge and output register. Depends on tpba_pkg.
module tpba_datapath #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tpba_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic [tpba_pkg::IN_W-1:0]     in_data,
  input  tpba_pkg::ctl_cmd_t            cmd,
  output tpba_pkg::ctl_sts_t            sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tpba_pkg::OUT_W-1:0]    m_tdata
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int LW = (AW + 1 > tpba_pkg::ADDR_W) ? AW + 1 : tpba_pkg::ADDR_W;
  localparam logic [LW-1:0] MEM_LIM   = LW'(MEM_BYTES);
  localparam logic [LW-1:0] LIMIT_RST = (MEM_BYTES < 65536) ? LW'(MEM_BYTES) : LW'(65536);

  // Unpacked input fields
  tpba_pkg::cmd_t                 in_cmd;
  logic [tpba_pkg::FMT_W-1:0]     in_fmt;
  logic [tpba_pkg::BASE_W-1:0]    in_base;
  logic [tpba_pkg::XY_W-1:0]      in_x;
  logic [tpba_pkg::XY_W-1:0]      in_y;
  logic [tpba_pkg::BYTE_W-1:0]    in_wv;
  logic                           in_byte;
  logic                           in_get;
  logic                           in_xbad;
  logic [tpba_pkg::CNT_W-1:0]     in_count;
  logic [tpba_pkg::ROW_W-1:0]     in_row;

  // Item registers
  logic                           item_get;
  logic                           item_byte;
  logic [tpba_pkg::FMT_W-1:0]     item_fmt;
  logic [tpba_pkg::XY_W-1:0]      item_x;
  logic [tpba_pkg::ROW_W-1:0]     row;
  logic [tpba_pkg::CNT_W-1:0]     count;
  logic [tpba_pkg::BYTE_W-1:0]    color, color_next;
  logic                           skipped;

  logic [LW-1:0]                  limit, limit_next;

  // Access stage
  tpba_pkg::acc_t                 desc;
  logic [tpba_pkg::ADDR_W-1:0]    addr;
  logic [LW-1:0]                  addr_ext;
  logic                           addr_ok;
  logic [LW-1:0]                  acc_addr;
  logic                           acc_ok;
  tpba_pkg::acc_t                 acc;

  logic [7:0]                     mem [MEM_BYTES];
  logic [7:0]                     rdata;
  logic [7:0]                     wbyte;
  logic                           mem_we;

  logic                           out_valid;
  logic [tpba_pkg::BYTE_W-1:0]    out_value;
  logic                           out_oor;

  // Decode the incoming item
  always_comb begin
    in_cmd   = tpba_pkg::cmd_t'(in_data[tpba_pkg::IN_CMD_LSB +: tpba_pkg::CMD_W]);
    in_fmt   = in_data[tpba_pkg::IN_FMT_LSB +: tpba_pkg::FMT_W];
    in_base  = in_data[tpba_pkg::IN_BASE_LSB +: tpba_pkg::BASE_W];
    in_x     = in_data[tpba_pkg::IN_X_LSB +: tpba_pkg::XY_W];
    in_y     = in_data[tpba_pkg::IN_Y_LSB +: tpba_pkg::XY_W];
    in_wv    = in_data[tpba_pkg::IN_WV_LSB +: tpba_pkg::BYTE_W];
    in_byte  = (in_cmd == tpba_pkg::CMD_WRITE_BYTE) || (in_cmd == tpba_pkg::CMD_READ_BYTE);
    in_get   = (in_cmd == tpba_pkg::CMD_READ_BYTE) || (in_cmd == tpba_pkg::CMD_GET_PIXEL);
    in_xbad  = !in_byte && (in_fmt <= tpba_pkg::FMT_PACK4_SWAP) &&
               !tpba_pkg::is_wide(in_fmt) && in_x[3];
    if (in_byte) begin
      in_count = tpba_pkg::CNT_W'(1);
      in_row   = tpba_pkg::ROW_W'(in_base);
    end else begin
      in_count = in_xbad ? '0 : tpba_pkg::acc_count(in_fmt);
      in_row   = tpba_pkg::ROW_W'(in_base) +
                 (tpba_pkg::ROW_W'(in_y) << tpba_pkg::stride_shift(in_fmt));
    end
  end

  // Byte address of the current access and its bound check
  always_comb begin
    if (item_byte) begin
      desc        = '0;
      desc.whole  = 1'b1;
    end else begin
      desc = tpba_pkg::acc_desc(item_fmt, item_x, cmd.step);
    end
    addr     = tpba_pkg::ADDR_W'(row) + tpba_pkg::ADDR_W'(desc.offset);
    addr_ext = LW'(addr);
    addr_ok  = addr_ext < limit;
  end

  // Gather a colour bit, or merge one into the byte to write back
  always_comb begin
    color_next = color;
    wbyte      = rdata;
    if (acc.whole) begin
      color_next = rdata;
      wbyte      = color;
    end else begin
      color_next[acc.cbit] = color[acc.cbit] | rdata[acc.pix];
      wbyte[acc.pix]       = color[acc.cbit];
    end
    mem_we = cmd.modify && acc_ok && !item_get;
  end

  always_comb begin
    limit_next = (LW'(cfg_wr_data) < MEM_LIM) ? LW'(cfg_wr_data) : MEM_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit <= limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_get  <= in_get;
      item_byte <= in_byte;
      item_fmt  <= in_fmt;
      item_x    <= in_x;
      row       <= in_row;
      count     <= in_count;
      color     <= in_get ? '0 : in_wv;
      skipped   <= in_xbad;
    end else if (cmd.modify) begin
      if (!acc_ok) begin
        skipped <= 1'b1;
      end else if (item_get) begin
        color <= color_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      acc_addr <= addr_ext;
      acc_ok   <= addr_ok;
      acc      <= desc;
    end
  end

  // Tile memory: read in read steps, written in modify steps, read data registered
  always_ff @(posedge clk) begin
    if (cmd.read && addr_ok) begin
      rdata <= mem[addr_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[acc_addr[AW-1:0]] <= wbyte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value <= item_get ? color : '0;
      out_oor   <= skipped;
    end
  end

  assign m_tvalid     = out_valid;
  assign m_tdata      = {{(tpba_pkg::OUT_W - tpba_pkg::BYTE_W - 1){1'b0}}, out_oor, out_value};
  assign sts.count    = count;
  assign sts.out_free = !out_valid || m_tready;

  a_modify_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.modify |-> $past(cmd.read))
    else $error("modify step without a preceding read step");

  a_skip_sticky: assert property (@(posedge clk) disable iff (rst)
    (!cmd.load && skipped) |=> skipped)
    else $error("skip flag dropped within an item");

endmodule
